[rtl/mart_pkg.sv]
// shared types and constants for the multicast address reference table
package mart_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int NUM_FILES   = 32;
    localparam int FILE_BITS   = 64;

    localparam int ADDR_W  = 64;
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int FID_W   = $clog2(NUM_FILES);
    localparam int REF_W   = 16;
    localparam int ALEN_W  = 4;
    localparam int CFG_W   = 4;
    localparam int CFGI_W  = 1;

    localparam logic [REF_W-1:0] REF_MAX = '1;

    // request codes
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_DEL   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_SUP = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // filter change codes
    localparam logic [1:0] CHG_NONE    = 2'd0;
    localparam logic [1:0] CHG_ENABLE  = 2'd1;
    localparam logic [1:0] CHG_DISABLE = 2'd2;

    // configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_ADDR_LEN = 1'b0;
    localparam logic [CFGI_W-1:0] CFG_MC_EN    = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LOAD,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic set_found;
        logic append;
        logic load;
        logic commit;
    } ctl_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic hit;
        logic scan_done;
        logic is_add;
        logic can_append;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/mart_ctrl.sv]
// sequencing state machine for the multicast address reference table
module mart_ctrl
    import mart_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t stat,
    output ctl_cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.need_scan ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    state_next = S_LOAD;
                end
                else if (stat.scan_done)
                begin
                    state_next = (stat.is_add && stat.can_append) ? S_LOAD : S_FINISH;
                end
            end
            S_LOAD:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.start = in_valid;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    cmd.set_found = 1'b1;
                end
                else if (stat.scan_done && stat.is_add && stat.can_append)
                begin
                    cmd.append = 1'b1;
                end
            end
            S_LOAD:
            begin
                cmd.load = 1'b1;
            end
            S_FINISH:
            begin
                cmd.commit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/mart_datapath.sv]
// table memories, scan compare, membership state and result register
module mart_datapath
    import mart_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFGI_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic [1:0]        req_type,
    input  logic [FID_W-1:0]  file_id,
    input  logic [ADDR_W-1:0] address,
    input  ctl_cmd_t          cmd,
    output dp_status_t        stat,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [1:0]        filter_change,
    output logic              is_active,
    output logic [IDX_W-1:0]  entry_index,
    output logic [CNT_W-1:0]  file_entry_count,
    output logic [CNT_W-1:0]  total_active_count
);

    // configuration
    logic [ALEN_W-1:0] addr_len_reg;
    logic              mc_en_reg;

    // latched request
    logic [1:0]        req_reg;
    logic [FID_W-1:0]  fid_reg;
    logic [ADDR_W-1:0] addr_reg;

    // scan
    logic [CNT_W-1:0]  used_reg;
    logic [CNT_W-1:0]  rd_idx_reg;
    logic              cmp_vld_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [ADDR_W-1:0] tbl_q_reg;
    logic              found_reg;
    logic              new_reg;
    logic [IDX_W-1:0]  pos_reg;
    logic [REF_W-1:0]  ref_rd_reg;
    logic [REF_W-1:0]  ref_cur;

    logic [ADDR_W-1:0] addr_mem [TABLE_DEPTH];
    logic [REF_W-1:0]  ref_mem  [TABLE_DEPTH];

    logic [FILE_BITS-1:0] memb_reg     [NUM_FILES];
    logic [CNT_W-1:0]     file_cnt_reg [NUM_FILES];
    logic [CNT_W-1:0]     active_cnt_reg;

    logic                 out_valid_reg;
    logic [1:0]           status_reg;
    logic [1:0]           change_reg;
    logic                 active_reg;
    logic [IDX_W-1:0]     index_reg;
    logic [CNT_W-1:0]     fcnt_out_reg;
    logic [CNT_W-1:0]     acnt_out_reg;

    logic [ADDR_W-1:0] cmp_mask;
    logic [ALEN_W-1:0] len_eff;
    logic              rd_issue;
    logic              hit;

    // commit results
    logic [1:0]       res_status;
    logic [1:0]       res_change;
    logic             res_active;
    logic [IDX_W-1:0] res_index;
    logic             wr_ref;
    logic [REF_W-1:0] ref_new;
    logic             memb_set;
    logic             memb_clr;
    logic [CNT_W-1:0] fcnt_cur;
    logic [CNT_W-1:0] fcnt_new;
    logic [CNT_W-1:0] acnt_new;
    logic             bit_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_len_reg <= ALEN_W'(6);
            mc_en_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ADDR_LEN: addr_len_reg <= cfg_data[ALEN_W-1:0];
                CFG_MC_EN:    mc_en_reg    <= cfg_data[0];
                default:      mc_en_reg    <= mc_en_reg;
            endcase
        end
    end

    // lengths above eight bytes compare the whole word
    always_comb
    begin
        len_eff = (addr_len_reg > ALEN_W'(8)) ? ALEN_W'(8) : addr_len_reg;
        for (int b = 0; b < 8; b++)
        begin
            cmp_mask[b*8 +: 8] = (ALEN_W'(b) < len_eff) ? 8'hff : 8'h00;
        end
    end

    assign rd_issue = cmd.scan && (rd_idx_reg < used_reg);
    assign hit      = cmp_vld_reg && (((tbl_q_reg ^ addr_reg) & cmp_mask) == '0);

    always_comb
    begin
        stat.need_scan  = (req_type == REQ_QUERY) ||
                          (((req_type == REQ_ADD) || (req_type == REQ_DEL)) && mc_en_reg);
        stat.hit        = hit;
        stat.scan_done  = !cmp_vld_reg && (rd_idx_reg == used_reg);
        stat.is_add     = (req_reg == REQ_ADD);
        stat.can_append = (used_reg != CNT_W'(TABLE_DEPTH));
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    // request latch
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_reg  <= req_type;
            fid_reg  <= file_id;
            addr_reg <= address;
        end
    end

    // scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            new_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                rd_idx_reg  <= '0;
                cmp_vld_reg <= 1'b0;
                found_reg   <= 1'b0;
                new_reg     <= 1'b0;
            end
            else if (cmd.scan)
            begin
                cmp_vld_reg <= rd_issue;
                if (rd_issue)
                begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
            end
            if (cmd.set_found)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.append)
            begin
                found_reg <= 1'b1;
                new_reg   <= 1'b1;
                used_reg  <= used_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_issue)
        begin
            cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
        if (cmd.set_found)
        begin
            pos_reg <= cmp_idx_reg;
        end
        else if (cmd.append)
        begin
            pos_reg <= used_reg[IDX_W-1:0];
        end
    end

    // address table
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            addr_mem[used_reg[IDX_W-1:0]] <= addr_reg;
        end
        if (rd_issue)
        begin
            tbl_q_reg <= addr_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    // reference counts
    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_ref)
        begin
            ref_mem[pos_reg] <= ref_new;
        end
        if (cmd.load)
        begin
            ref_rd_reg <= ref_mem[pos_reg];
        end
    end

    // a freshly appended entry starts from zero
    assign ref_cur  = new_reg ? '0 : ref_rd_reg;
    assign fcnt_cur = file_cnt_reg[fid_reg];
    assign bit_cur  = memb_reg[fid_reg][pos_reg];

    always_comb
    begin
        res_status = ST_OK;
        res_change = CHG_NONE;
        res_active = 1'b0;
        res_index  = '0;
        wr_ref     = 1'b0;
        ref_new    = ref_cur;
        memb_set   = 1'b0;
        memb_clr   = 1'b0;
        fcnt_new   = fcnt_cur;
        acnt_new   = active_cnt_reg;
        case (req_reg)
            REQ_QUERY:
            begin
                if (found_reg)
                begin
                    res_index  = pos_reg;
                    res_active = (ref_cur != '0);
                end
            end
            REQ_ADD:
            begin
                if (!mc_en_reg)
                begin
                    res_status = ST_NOT_SUP;
                end
                else if (!found_reg)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    res_index = pos_reg;
                    wr_ref    = 1'b1;
                    if (ref_cur == '0)
                    begin
                        ref_new    = REF_W'(1);
                        acnt_new   = active_cnt_reg + CNT_W'(1);
                        res_change = CHG_ENABLE;
                    end
                    else if (ref_cur != REF_MAX)
                    begin
                        ref_new = ref_cur + REF_W'(1);
                    end
                    if (!bit_cur)
                    begin
                        memb_set = 1'b1;
                        fcnt_new = fcnt_cur + CNT_W'(1);
                    end
                end
            end
            REQ_DEL:
            begin
                if (!mc_en_reg)
                begin
                    res_status = ST_NOT_SUP;
                end
                else if (found_reg)
                begin
                    res_index = pos_reg;
                    if (ref_cur != '0)
                    begin
                        wr_ref  = 1'b1;
                        ref_new = ref_cur - REF_W'(1);
                        if (ref_cur == REF_W'(1))
                        begin
                            res_change = CHG_DISABLE;
                            if (active_cnt_reg != '0)
                            begin
                                acnt_new = active_cnt_reg - CNT_W'(1);
                            end
                        end
                        if (bit_cur)
                        begin
                            memb_clr = 1'b1;
                            if (fcnt_cur != '0)
                            begin
                                fcnt_new = fcnt_cur - CNT_W'(1);
                            end
                        end
                    end
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    // per-file membership and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int f = 0; f < NUM_FILES; f++)
            begin
                memb_reg[f]     <= '0;
                file_cnt_reg[f] <= '0;
            end
            active_cnt_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (memb_set)
            begin
                memb_reg[fid_reg][pos_reg] <= 1'b1;
            end
            else if (memb_clr)
            begin
                memb_reg[fid_reg][pos_reg] <= 1'b0;
            end
            file_cnt_reg[fid_reg] <= fcnt_new;
            active_cnt_reg        <= acnt_new;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg   <= res_status;
            change_reg   <= res_change;
            active_reg   <= res_active;
            index_reg    <= res_index;
            fcnt_out_reg <= fcnt_new;
            acnt_out_reg <= acnt_new;
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = status_reg;
    assign filter_change      = change_reg;
    assign is_active          = active_reg;
    assign entry_index        = index_reg;
    assign file_entry_count   = fcnt_out_reg;
    assign total_active_count = acnt_out_reg;

endmodule

[rtl/multicast_address_ref_table_top.sv]
// multicast address reference table: top level
// requests come in on in_valid/in_stall with req_type, file_id and address;
// each request gives exactly one result on out_valid/out_stall.
// add finds or appends the address and counts it up, delete counts it down,
// query reports whether the address is present with a nonzero count.
// the user writes configuration (addr_len, multicast_enabled) through cfg_we,
// cfg_index and cfg_data while no request is in flight; not enforced by the block.
// a request is taken only while the block is idle; the stored addresses are
// then compared one per cycle through the single read port of the address
// table, and a match ends the scan early.
// add and delete with multicast disabled, and the unused code, skip the scan.
// the result sits in an output register: the next request is taken while it
// still waits, and a stalled result holds until taken; a finished request
// that finds the output register full waits with in_stall high.
// reset empties the table and clears all counts and memberships at once,
// with no clearing pass; addr_len returns to 6 and multicast is disabled.
module multicast_address_ref_table_top
    import mart_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFGI_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        req_type,
    input  logic [FID_W-1:0]  file_id,
    input  logic [ADDR_W-1:0] address,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [1:0]        filter_change,
    output logic              is_active,
    output logic [IDX_W-1:0]  entry_index,
    output logic [CNT_W-1:0]  file_entry_count,
    output logic [CNT_W-1:0]  total_active_count
);

    ctl_cmd_t   cmd;
    dp_status_t stat;

    mart_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    mart_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .req_type           (req_type),
        .file_id            (file_id),
        .address            (address),
        .cmd                (cmd),
        .stat               (stat),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .status             (status),
        .filter_change      (filter_change),
        .is_active          (is_active),
        .entry_index        (entry_index),
        .file_entry_count   (file_entry_count),
        .total_active_count (total_active_count)
    );

endmodule
